### design/igfr_pkg.sv
// igfr_pkg: shared types and constants for the idle-gap frame and ring receiver
// holds the input item, result item and status types and the register indexes
// no dependencies
package igfr_pkg;

  typedef enum logic [1:0] {
    ACT_BYTE  = 2'd0,
    ACT_ERROR = 2'd1,
    ACT_TICK  = 2'd2,
    ACT_DRAIN = 2'd3
  } action_e;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_STREAM_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_LIMIT  = 1'b1;

  localparam logic [15:0] IDLE_LIMIT_RST = 16'd5;

  // result queue in the back end
  localparam int unsigned OQ_DEPTH = 4;
  localparam int unsigned OQ_AW    = $clog2(OQ_DEPTH);
  localparam int unsigned OQ_CW    = $clog2(OQ_DEPTH + 1);

  typedef struct packed {
    action_e     action;
    logic [7:0]  data_in;
  } in_item_t;

  typedef struct packed {
    logic        frame_pending;
    logic [31:0] rx_total;
    logic [31:0] error_total;
    logic [15:0] overflow_total;
  } status_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        data_valid;
    logic        last;
    logic        frame_pending;
    logic [31:0] rx_total;
    logic [31:0] error_total;
    logic [15:0] overflow_total;
  } result_t;

endpackage

### design/igfr_front.sv
// igfr_front: accepts input items and configuration writes, keeps framing,
// ring and counter state, writes bytes to the store and issues emit jobs
// depends on igfr_pkg
module igfr_front #(
  parameter int unsigned BUF_DEPTH = 64,
  parameter int unsigned AW        = $clog2(BUF_DEPTH),
  parameter int unsigned CW        = $clog2(BUF_DEPTH + 1)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [igfr_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [igfr_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                push,
  output logic                                full,
  input  igfr_pkg::in_item_t                  in_item_i,
  input  logic                                job_full_i,
  input  logic                                drain_done_i,
  output logic                                job_push_o,
  output logic [AW-1:0]                       job_start_o,
  output logic [CW-1:0]                       job_count_o,
  output igfr_pkg::status_t                   job_stat_o,
  output logic                                wr_en_o,
  output logic [AW-1:0]                       wr_addr_o,
  output logic [7:0]                          wr_data_o
);
  import igfr_pkg::*;

  localparam logic [CW-1:0] DEPTH_C  = CW'(BUF_DEPTH);
  localparam logic [AW-1:0] LAST_PTR = AW'(BUF_DEPTH - 1);

  logic          mode_q, mode_d;
  logic [15:0]   limit_q, limit_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [15:0]   idle_q, idle_d;
  logic          pend_q, pend_d;
  logic [CW-1:0] plen_q, plen_d;
  logic [AW-1:0] head_q, head_d;
  logic [AW-1:0] tail_q, tail_d;
  logic [15:0]   ovf_q, ovf_d;
  logic [31:0]   rx_q, rx_d;
  logic [31:0]   err_q, err_d;
  logic          busy_q, busy_d;

  logic          accept;
  logic [AW-1:0] head_inc;
  logic [CW-1:0] head_ext, tail_ext;

  assign full      = job_full_i | busy_q;
  assign accept    = push & ~full;
  assign head_inc  = (head_q == LAST_PTR) ? '0 : head_q + 1'b1;
  assign head_ext  = CW'(head_q);
  assign tail_ext  = CW'(tail_q);
  assign wr_data_o = in_item_i.data_in;

  always_comb begin
    mode_d      = mode_q;
    limit_d     = limit_q;
    fill_d      = fill_q;
    idle_d      = idle_q;
    pend_d      = pend_q;
    plen_d      = plen_q;
    head_d      = head_q;
    tail_d      = tail_q;
    ovf_d       = ovf_q;
    rx_d        = rx_q;
    err_d       = err_q;
    busy_d      = busy_q;
    wr_en_o     = 1'b0;
    wr_addr_o   = head_q;
    job_start_o = '0;
    job_count_o = '0;

    if (drain_done_i) begin
      busy_d = 1'b0;
    end

    if (cfg_we_i) begin
      if (cfg_idx_i == REG_STREAM_MODE) begin
        mode_d = cfg_data_i[0];
        fill_d = '0;
        idle_d = '0;
        pend_d = 1'b0;
        plen_d = '0;
        head_d = '0;
        tail_d = '0;
        ovf_d  = '0;
      end else begin
        limit_d = cfg_data_i;
      end
    end else if (accept) begin
      case (in_item_i.action)
        ACT_BYTE: begin
          rx_d = rx_q + 32'd1;
          if (mode_q) begin
            if (head_inc == tail_q) begin
              ovf_d = ovf_q + 16'd1;
            end else begin
              wr_en_o   = 1'b1;
              wr_addr_o = head_q;
              head_d    = head_inc;
            end
          end else if (!pend_q) begin
            if (fill_q < DEPTH_C) begin
              wr_en_o   = 1'b1;
              wr_addr_o = fill_q[AW-1:0];
              fill_d    = fill_q + 1'b1;
              idle_d    = '0;
            end
            if (fill_d >= DEPTH_C && fill_d != '0) begin
              pend_d = 1'b1;
              plen_d = fill_d;
            end
          end
        end
        ACT_ERROR: begin
          err_d = err_q + 32'd1;
        end
        ACT_TICK: begin
          if (!mode_q && !pend_q && fill_q != '0) begin
            if (idle_q >= limit_q) begin
              pend_d = 1'b1;
              plen_d = fill_q;
            end else begin
              idle_d = idle_q + 16'd1;
            end
          end
        end
        ACT_DRAIN: begin
          if (mode_q) begin
            job_start_o = tail_q;
            job_count_o = (head_q >= tail_q) ? head_ext - tail_ext
                                             : head_ext + DEPTH_C - tail_ext;
            tail_d      = head_q;
          end else if (pend_q) begin
            job_start_o = '0;
            job_count_o = plen_q;
            fill_d      = '0;
            idle_d      = '0;
            pend_d      = 1'b0;
            plen_d      = '0;
            head_d      = '0;
            tail_d      = '0;
            ovf_d       = '0;
          end
          if (job_count_o != '0) begin
            busy_d = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign job_push_o = accept;
  assign job_stat_o = '{frame_pending:  pend_d,
                        rx_total:       rx_d,
                        error_total:    err_d,
                        overflow_total: ovf_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      limit_q <= IDLE_LIMIT_RST;
      fill_q  <= '0;
      idle_q  <= '0;
      pend_q  <= 1'b0;
      plen_q  <= '0;
      head_q  <= '0;
      tail_q  <= '0;
      ovf_q   <= '0;
      rx_q    <= '0;
      err_q   <= '0;
      busy_q  <= 1'b0;
    end else begin
      mode_q  <= mode_d;
      limit_q <= limit_d;
      fill_q  <= fill_d;
      idle_q  <= idle_d;
      pend_q  <= pend_d;
      plen_q  <= plen_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      ovf_q   <= ovf_d;
      rx_q    <= rx_d;
      err_q   <= err_d;
      busy_q  <= busy_d;
    end
  end

endmodule

### design/igfr_back.sv
// igfr_back: job queue, byte store, read sequencer and result queue
// turns each job into one or more result items, one store read per cycle while the result queue has room
// depends on igfr_pkg
module igfr_back #(
  parameter int unsigned BUF_DEPTH = 64,
  parameter int unsigned AW        = $clog2(BUF_DEPTH),
  parameter int unsigned CW        = $clog2(BUF_DEPTH + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_push_i,
  input  logic [AW-1:0]     job_start_i,
  input  logic [CW-1:0]     job_count_i,
  input  igfr_pkg::status_t job_stat_i,
  output logic              job_full_o,
  output logic              drain_done_o,
  input  logic              wr_en_i,
  input  logic [AW-1:0]     wr_addr_i,
  input  logic [7:0]        wr_data_i,
  output logic              empty,
  input  logic              pop,
  output igfr_pkg::result_t result_o
);
  import igfr_pkg::*;

  localparam logic [AW-1:0] LAST_PTR = AW'(BUF_DEPTH - 1);

  // job queue, two entries
  logic [AW-1:0] jq_start [2];
  logic [CW-1:0] jq_count [2];
  status_t       jq_stat  [2];
  logic          jq_wp_q, jq_rp_q;
  logic [1:0]    jq_cnt_q;
  logic          jq_pop;

  // sequencer
  logic          act_q;
  logic [AW-1:0] addr_q;
  logic [CW-1:0] rem_q;
  status_t       stat_q;
  logic          issue;

  // store and read stage
  logic [7:0]    mem [BUF_DEPTH];
  logic [7:0]    rd_data_q;
  logic          infl_q;
  logic          meta_valid_q, meta_last_q;
  status_t       meta_stat_q;

  // result queue
  result_t          oq [OQ_DEPTH];
  logic [OQ_AW-1:0] oq_wp_q, oq_rp_q;
  logic [OQ_CW-1:0] oq_cnt_q;
  logic             oq_pop;

  assign job_full_o   = (jq_cnt_q == 2'd2);
  assign jq_pop       = ~act_q & (jq_cnt_q != 2'd0);
  assign issue        = act_q &
                        ((OQ_CW + 1)'(oq_cnt_q) + (OQ_CW + 1)'(infl_q) <
                         (OQ_CW + 1)'(OQ_DEPTH));
  assign drain_done_o = issue & (rem_q == CW'(1));
  assign empty        = (oq_cnt_q == '0);
  assign oq_pop       = pop & ~empty;
  assign result_o     = oq[oq_rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      jq_wp_q  <= 1'b0;
      jq_rp_q  <= 1'b0;
      jq_cnt_q <= 2'd0;
      act_q    <= 1'b0;
      addr_q   <= '0;
      rem_q    <= '0;
      infl_q   <= 1'b0;
      oq_wp_q  <= '0;
      oq_rp_q  <= '0;
      oq_cnt_q <= '0;
    end else begin
      if (job_push_i) begin
        jq_wp_q <= ~jq_wp_q;
      end
      if (jq_pop) begin
        jq_rp_q <= ~jq_rp_q;
      end
      jq_cnt_q <= jq_cnt_q + 2'(job_push_i) - 2'(jq_pop);

      if (jq_pop) begin
        act_q  <= 1'b1;
        addr_q <= jq_start[jq_rp_q];
        rem_q  <= jq_count[jq_rp_q];
      end else if (issue) begin
        if (rem_q <= CW'(1)) begin
          act_q <= 1'b0;
        end else begin
          rem_q  <= rem_q - 1'b1;
          addr_q <= (addr_q == LAST_PTR) ? '0 : addr_q + 1'b1;
        end
      end

      infl_q <= issue;

      if (infl_q) begin
        oq_wp_q <= oq_wp_q + 1'b1;
      end
      if (oq_pop) begin
        oq_rp_q <= oq_rp_q + 1'b1;
      end
      oq_cnt_q <= oq_cnt_q + OQ_CW'(infl_q) - OQ_CW'(oq_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_push_i) begin
      jq_start[jq_wp_q] <= job_start_i;
      jq_count[jq_wp_q] <= job_count_i;
      jq_stat[jq_wp_q]  <= job_stat_i;
    end
    if (jq_pop) begin
      stat_q <= jq_stat[jq_rp_q];
    end
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (issue) begin
      rd_data_q    <= mem[addr_q];
      meta_valid_q <= (rem_q != '0);
      meta_last_q  <= (rem_q <= CW'(1));
      meta_stat_q  <= stat_q;
    end
    if (infl_q) begin
      oq[oq_wp_q] <= '{data_byte:      meta_valid_q ? rd_data_q : 8'd0,
                       data_valid:     meta_valid_q,
                       last:           meta_last_q,
                       frame_pending:  meta_stat_q.frame_pending,
                       rx_total:       meta_stat_q.rx_total,
                       error_total:    meta_stat_q.error_total,
                       overflow_total: meta_stat_q.overflow_total};
    end
  end

endmodule

### design/idle_gap_frame_and_ring_receiver_core.sv
// flow: each item's job is loaded from a two-entry job queue, which takes bursts, and is then read
// out of the store result by result while the result queue has room; no new item is taken during
// a drain of bytes until the last byte of that drain has been read
// reset: counters, framing and ring state clear, idle limit is 5, frame mode; store contents
// stay undefined until written
module idle_gap_frame_and_ring_receiver_core #(
  parameter int unsigned BUF_DEPTH = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [igfr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [igfr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            push,
  output logic                            full,
  input  igfr_pkg::in_item_t              in_item_i,
  output logic                            empty,
  input  logic                            pop,
  output igfr_pkg::result_t               result_o
);
  import igfr_pkg::*;

  localparam int unsigned AW = $clog2(BUF_DEPTH);
  localparam int unsigned CW = $clog2(BUF_DEPTH + 1);

  logic          job_push, job_full, drain_done;
  logic [AW-1:0] job_start;
  logic [CW-1:0] job_count;
  status_t       job_stat;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;

  igfr_front #(
    .BUF_DEPTH (BUF_DEPTH),
    .AW        (AW),
    .CW        (CW)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .push         (push),
    .full         (full),
    .in_item_i    (in_item_i),
    .job_full_i   (job_full),
    .drain_done_i (drain_done),
    .job_push_o   (job_push),
    .job_start_o  (job_start),
    .job_count_o  (job_count),
    .job_stat_o   (job_stat),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .wr_data_o    (wr_data)
  );

  igfr_back #(
    .BUF_DEPTH (BUF_DEPTH),
    .AW        (AW),
    .CW        (CW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_push_i   (job_push),
    .job_start_i  (job_start),
    .job_count_i  (job_count),
    .job_stat_i   (job_stat),
    .job_full_o   (job_full),
    .drain_done_o (drain_done),
    .wr_en_i      (wr_en),
    .wr_addr_i    (wr_addr),
    .wr_data_i    (wr_data),
    .empty        (empty),
    .pop          (pop),
    .result_o     (result_o)
  );

endmodule

### bench/tb_idle_gap_frame_and_ring_receiver_core.sv
// tb_idle_gap_frame_and_ring_receiver_core: self-checking bench for the receive framer core
// drives byte, error, tick and drain events through the queue ports, mirrors the channel
// state in a local predictor and checks every result transfer; depends on igfr_pkg and the core
module tb_idle_gap_frame_and_ring_receiver_core;
  import igfr_pkg::*;

  localparam int DEPTH = 64;

  logic                  clk_i      = 1'b0;
  logic                  rst_ni     = 1'b0;
  logic                  cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i  = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  push       = 1'b0;
  logic                  full;
  in_item_t              in_item_i  = '0;
  logic                  empty;
  logic                  pop        = 1'b0;
  result_t               result_o;

  idle_gap_frame_and_ring_receiver_core #(
    .BUF_DEPTH(DEPTH)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .push      (push),
    .full      (full),
    .in_item_i (in_item_i),
    .empty     (empty),
    .pop       (pop),
    .result_o  (result_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // mirrored channel state
  logic [7:0]  rcv_store [DEPTH];
  logic [6:0]  rcv_fill  = '0;
  logic [15:0] rcv_idle  = '0;
  logic        rcv_pend  = 1'b0;
  logic [6:0]  rcv_plen  = '0;
  logic [5:0]  rcv_head  = '0;
  logic [5:0]  rcv_tail  = '0;
  logic [15:0] rcv_ovf   = '0;
  logic [31:0] rcv_rx    = '0;
  logic [31:0] rcv_err   = '0;
  logic        rcv_stream = 1'b0;
  logic [15:0] rcv_limit  = IDLE_LIMIT_RST;

  result_t rx_results_due [$];

  int items_sent      = 0;
  int results_checked = 0;
  int mismatches      = 0;
  int reg_writes      = 0;
  int frames_out      = 0;
  int ring_bytes_out  = 0;
  int overflow_hits   = 0;
  int burst_left      = 0;
  bit push_open       = 1'b0;

  function automatic logic [5:0] ring_advance(logic [5:0] p);
    return (p == 6'(DEPTH - 1)) ? 6'd0 : p + 6'd1;
  endfunction

  task automatic channel_clear();
    rcv_fill = '0;
    rcv_idle = '0;
    rcv_pend = 1'b0;
    rcv_plen = '0;
    rcv_head = '0;
    rcv_tail = '0;
    rcv_ovf  = '0;
  endtask

  task automatic receiver_step(input in_item_t it);
    logic [7:0] out_bytes [$];
    logic [5:0] nxt;
    result_t    r;
    case (it.action)
      ACT_BYTE: begin
        rcv_rx = rcv_rx + 32'd1;
        if (rcv_stream) begin
          nxt = ring_advance(rcv_head);
          if (nxt == rcv_tail) begin
            rcv_ovf = rcv_ovf + 16'd1;
            overflow_hits++;
          end else begin
            rcv_store[rcv_head] = it.data_in;
            rcv_head = nxt;
          end
        end else if (!rcv_pend) begin
          if (rcv_fill < DEPTH) begin
            rcv_store[rcv_fill] = it.data_in;
            rcv_fill = rcv_fill + 7'd1;
            rcv_idle = '0;
          end
          if (rcv_fill >= DEPTH) begin
            rcv_plen = rcv_fill;
            rcv_pend = 1'b1;
          end
        end
      end
      ACT_ERROR: rcv_err = rcv_err + 32'd1;
      ACT_TICK: begin
        if (!rcv_stream && !rcv_pend && rcv_fill != 0) begin
          if (rcv_idle >= rcv_limit) begin
            rcv_plen = rcv_fill;
            rcv_pend = 1'b1;
          end else begin
            rcv_idle = rcv_idle + 16'd1;
          end
        end
      end
      default: begin
        if (rcv_stream) begin
          while (rcv_tail != rcv_head) begin
            out_bytes.push_back(rcv_store[rcv_tail]);
            rcv_tail = ring_advance(rcv_tail);
          end
          ring_bytes_out += out_bytes.size();
        end else if (rcv_pend) begin
          for (int i = 0; i < rcv_plen; i++) out_bytes.push_back(rcv_store[i]);
          channel_clear();
          frames_out++;
        end
      end
    endcase
    r.frame_pending  = rcv_pend;
    r.rx_total       = rcv_rx;
    r.error_total    = rcv_err;
    r.overflow_total = rcv_ovf;
    if (out_bytes.size() == 0) begin
      r.data_byte  = '0;
      r.data_valid = 1'b0;
      r.last       = 1'b1;
      rx_results_due.push_back(r);
    end else begin
      foreach (out_bytes[i]) begin
        r.data_byte  = out_bytes[i];
        r.data_valid = 1'b1;
        r.last       = (i == out_bytes.size() - 1);
        rx_results_due.push_back(r);
      end
    end
  endtask

  // lowers push in the step of the last transfer before time moves on
  task automatic sender_hold();
    if (push_open) begin
      push <= 1'b0;
      push_open = 1'b0;
    end
  endtask

  task automatic send_item(input action_e act, input logic [7:0] data);
    in_item_t it;
    it.action  = act;
    it.data_in = data;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        sender_hold();
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
    burst_left--;
    push      <= 1'b1;
    in_item_i <= it;
    push_open = 1'b1;
    do @(posedge clk_i); while (full);
    items_sent++;
    receiver_step(it);
  endtask

  task automatic wait_results_done();
    sender_hold();
    while (rx_results_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    wait_results_done();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    reg_writes++;
    if (idx == REG_STREAM_MODE) begin
      rcv_stream = val[0];
      foreach (rcv_store[i]) rcv_store[i] = '0;
      channel_clear();
    end else begin
      rcv_limit = val;
    end
  endtask

  task automatic send_frame_sequence();
    int len;
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) len = DEPTH;
    else if (pick == 1) len = $urandom_range(30, DEPTH - 1);
    else len = $urandom_range(1, 8);
    for (int i = 0; i < len; i++) begin
      send_item(ACT_BYTE, 8'($urandom));
      if ($urandom_range(0, 9) == 0) send_item(ACT_ERROR, 8'($urandom));
    end
    if (rcv_limit > 8) begin
      while (!rcv_pend) send_item(ACT_BYTE, 8'($urandom));
    end else begin
      while (!rcv_pend) begin
        pick = $urandom_range(0, 11);
        if (pick == 0) send_item(ACT_BYTE, 8'($urandom));
        else if (pick == 1) send_item(ACT_DRAIN, 8'($urandom));
        else send_item(ACT_TICK, 8'($urandom));
      end
    end
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) send_item(ACT_BYTE, 8'($urandom));
    if ($urandom_range(0, 4) == 0) send_item(ACT_TICK, 8'($urandom));
    send_item(ACT_DRAIN, 8'($urandom));
  endtask

  task automatic send_ring_sequence();
    int k;
    int pick;
    k = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 75) : $urandom_range(0, 12);
    for (int i = 0; i < k; i++) begin
      pick = $urandom_range(0, 19);
      if (pick < 17) send_item(ACT_BYTE, 8'($urandom));
      else if (pick == 17) send_item(ACT_ERROR, 8'($urandom));
      else if (pick == 18) send_item(ACT_TICK, 8'($urandom));
      else send_item(ACT_DRAIN, 8'($urandom));
    end
    if ($urandom_range(0, 4) != 0) send_item(ACT_DRAIN, 8'($urandom));
  endtask

  task automatic test_frame_directed();
    send_item(ACT_TICK, 8'($urandom));
    send_item(ACT_DRAIN, 8'($urandom));
    send_item(ACT_ERROR, 8'($urandom));
    send_item(ACT_BYTE, 8'h00);
    send_item(ACT_BYTE, 8'hFF);
    send_item(ACT_TICK, 8'($urandom));
    write_reg(REG_IDLE_LIMIT, 16'd0);
    send_item(ACT_TICK, 8'($urandom));
    send_item(ACT_BYTE, 8'h5A);
    send_item(ACT_TICK, 8'($urandom));
    send_item(ACT_DRAIN, 8'($urandom));
    send_item(ACT_DRAIN, 8'($urandom));
  endtask

  task automatic test_mode_write_clears();
    send_item(ACT_BYTE, 8'h11);
    send_item(ACT_BYTE, 8'h22);
    write_reg(REG_STREAM_MODE, 16'd0);
    send_item(ACT_TICK, 8'($urandom));
    send_item(ACT_DRAIN, 8'($urandom));
    send_item(ACT_BYTE, 8'h33);
    send_item(ACT_TICK, 8'($urandom));
    send_item(ACT_DRAIN, 8'($urandom));
  endtask

  task automatic test_stream_directed();
    write_reg(REG_STREAM_MODE, 16'd1);
    send_item(ACT_BYTE, 8'h81);
    send_item(ACT_BYTE, 8'h7E);
    send_item(ACT_TICK, 8'($urandom));
    send_item(ACT_ERROR, 8'($urandom));
    send_item(ACT_DRAIN, 8'($urandom));
    send_item(ACT_DRAIN, 8'($urandom));
  endtask

  task automatic test_idle_gap_frames();
    int stop_at;
    logic [15:0] limits [3] = '{16'd3, 16'd1, IDLE_LIMIT_RST};
    write_reg(REG_STREAM_MODE, 16'd0);
    foreach (limits[j]) begin
      write_reg(REG_IDLE_LIMIT, limits[j]);
      stop_at = items_sent + 35;
      while (items_sent < stop_at) begin
        send_frame_sequence();
        // pause until the block has nothing left to hand out
        if (j == 0 && items_sent >= stop_at - 25 && items_sent < stop_at - 15)
          wait_results_done();
      end
    end
  endtask

  task automatic test_full_frames();
    int stop_at;
    write_reg(REG_IDLE_LIMIT, 16'hFFFF);
    write_reg(REG_STREAM_MODE, 16'd0);
    stop_at = items_sent + 60;
    while (items_sent < stop_at) send_frame_sequence();
  endtask

  task automatic test_ring_stream();
    int stop_at;
    write_reg(REG_STREAM_MODE, 16'd1);
    stop_at = items_sent + 60;
    while (items_sent < stop_at) send_ring_sequence();
    // ring is usually not empty here, the rewrite has to clear it
    write_reg(REG_IDLE_LIMIT, 16'd2);
    write_reg(REG_STREAM_MODE, 16'd1);
    stop_at = items_sent + 60;
    while (items_sent < stop_at) send_ring_sequence();
  endtask

  task automatic test_mixed_noise();
    write_reg(REG_IDLE_LIMIT, 16'd0);
    for (int m = 0; m < 3; m++) begin
      write_reg(REG_STREAM_MODE, 16'(m % 2));
      repeat (20) send_item(action_e'($urandom_range(0, 3)), 8'($urandom));
    end
  endtask

  always @(posedge clk_i) begin : check_results
    result_t want;
    string   diffs;
    if (rst_ni && pop && !empty) begin
      if (rx_results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result with nothing expected: byte %02h valid %b last %b",
                   result_o.data_byte, result_o.data_valid, result_o.last);
      end else begin
        want = rx_results_due.pop_front();
        results_checked++;
        diffs = "";
        if (result_o.data_byte !== want.data_byte) diffs = {diffs, " data_byte"};
        if (result_o.data_valid !== want.data_valid) diffs = {diffs, " data_valid"};
        if (result_o.last !== want.last) diffs = {diffs, " last"};
        if (result_o.frame_pending !== want.frame_pending) diffs = {diffs, " frame_pending"};
        if (result_o.rx_total !== want.rx_total) diffs = {diffs, " rx_total"};
        if (result_o.error_total !== want.error_total) diffs = {diffs, " error_total"};
        if (result_o.overflow_total !== want.overflow_total) diffs = {diffs, " overflow_total"};
        if (diffs != "") begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result %0d wrong in%s: exp byte %02h v %b l %b p %b rx %0d err %0d ovf %0d",
                     results_checked, diffs, want.data_byte, want.data_valid, want.last,
                     want.frame_pending, want.rx_total, want.error_total, want.overflow_total);
            $display("      got byte %02h v %b l %b p %b rx %0d err %0d ovf %0d",
                     result_o.data_byte, result_o.data_valid, result_o.last,
                     result_o.frame_pending, result_o.rx_total, result_o.error_total,
                     result_o.overflow_total);
          end
        end
      end
    end
  end

  // receiver stalls: full rate, coin flips, mostly ready, or long stall bursts
  int pop_style = 0;
  int pop_left  = 0;
  always @(posedge clk_i) begin
    if (pop_left == 0) begin
      pop_style = $urandom_range(0, 3);
      pop_left  = $urandom_range(16, 80);
    end
    pop_left--;
    case (pop_style)
      0: pop <= 1'b1;
      1: pop <= 1'($urandom_range(0, 1));
      2: pop <= ($urandom_range(0, 9) < 8);
      default: pop <= (pop_left % 8 == 0);
    endcase
  end

  initial begin
    int tail_wait;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_frame_directed();
    test_mode_write_clears();
    test_stream_directed();
    test_idle_gap_frames();
    test_full_frames();
    test_ring_stream();
    test_mixed_noise();
    sender_hold();
    tail_wait = 0;
    while (rx_results_due.size() != 0 && tail_wait < 50000) begin
      @(posedge clk_i);
      tail_wait++;
    end
    repeat (12) @(posedge clk_i);
    if (rx_results_due.size() != 0) begin
      $display("%0d expected results never arrived", rx_results_due.size());
      mismatches += rx_results_due.size();
    end
    $display("covered %0d items over %0d register writes in frame and ring modes",
             items_sent, reg_writes);
    $display("checked %0d results: %0d frames, %0d ring bytes, %0d ring overflows",
             results_checked, frames_out, ring_bytes_out, overflow_hits);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("run timed out");
    $display("Mismatches found");
    $finish;
  end

endmodule
